FILE: design/necpb_pkg.sv
// Shared constants, types and the sequencer program for the NEC frame pulse builder.
package necpb_pkg;

    // Field widths of the channels.
    localparam int ADDR_W    = 16;
    localparam int TICK_W    = 6;
    localparam int CMD_W     = 8;
    localparam int DUR_W     = 15;
    localparam int CFG_IDX_W = 1;

    // Durations in units of 10 us, and the width of a scaled product.
    localparam int BASE_W = 10;
    localparam int PROD_W = BASE_W + TICK_W;

    localparam int PAYLOAD_BITS_DEF = 32;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_ADDRESS    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_TEN_US = 1'd1;

    // Configuration reset values.
    localparam logic [ADDR_W-1:0] ADDR_RESET = 16'hFF00;
    localparam logic [TICK_W-1:0] TICK_RESET = 6'd8;

    // Pulse lengths in units of 10 us.
    localparam logic [BASE_W-1:0] HDR_MARK_U   = 10'd900;
    localparam logic [BASE_W-1:0] HDR_SPACE_U  = 10'd450;
    localparam logic [BASE_W-1:0] BIT_MARK_U   = 10'd56;
    localparam logic [BASE_W-1:0] ONE_SPACE_U  = 10'd169;
    localparam logic [BASE_W-1:0] ZERO_SPACE_U = 10'd56;

    // Largest duration that fits the output fields.
    localparam logic [DUR_W-1:0] DUR_MAX = 15'h7FFF;

    // Sequencer program addresses.
    localparam int UPC_W = 2;
    localparam logic [UPC_W-1:0] STEP_HEADER  = 2'd0;
    localparam logic [UPC_W-1:0] STEP_BIT     = 2'd1;
    localparam logic [UPC_W-1:0] STEP_TRAILER = 2'd2;

    typedef enum logic {
        MARK_HDR = 1'b0,
        MARK_BIT = 1'b1
    } mark_sel_t;

    typedef enum logic [1:0] {
        SPACE_HDR  = 2'd0,
        SPACE_DATA = 2'd1,
        SPACE_NONE = 2'd2
    } space_sel_t;

    typedef enum logic {
        BR_NEXT      = 1'b0,
        BR_BITS_LEFT = 1'b1
    } br_cond_t;

    // One control word of the sequencer program.
    typedef struct packed {
        mark_sel_t        mark_sel;
        space_sel_t       space_sel;
        logic             last;
        logic             shift;
        br_cond_t         br_cond;
        logic [UPC_W-1:0] br_target;
        logic             end_frame;
    } uword_t;

    // Program: header pair, one pair per payload bit (loops on itself), trailer pair.
    function automatic uword_t ucode_rom(input logic [UPC_W-1:0] addr);
        uword_t w;
        unique case (addr)
            STEP_HEADER: w = '{mark_sel: MARK_HDR, space_sel: SPACE_HDR, last: 1'b0,
                               shift: 1'b0, br_cond: BR_NEXT, br_target: STEP_HEADER,
                               end_frame: 1'b0};
            STEP_BIT:    w = '{mark_sel: MARK_BIT, space_sel: SPACE_DATA, last: 1'b0,
                               shift: 1'b1, br_cond: BR_BITS_LEFT, br_target: STEP_BIT,
                               end_frame: 1'b0};
            default:     w = '{mark_sel: MARK_BIT, space_sel: SPACE_NONE, last: 1'b1,
                               shift: 1'b0, br_cond: BR_NEXT, br_target: STEP_TRAILER,
                               end_frame: 1'b1};
        endcase
        return w;
    endfunction

endpackage

FILE: design/necpb_if.sv
// Channel interfaces of the NEC frame pulse builder: command, pulse and configuration.

// Command byte channel.
interface necpb_cmd_if import necpb_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] command_byte;

    modport source (output valid, output command_byte, input ready);
    modport sink   (input valid, input command_byte, output ready);
endinterface

// Pulse pair channel.
interface necpb_pulse_if import necpb_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [DUR_W-1:0] mark_ticks;
    logic [DUR_W-1:0] space_ticks;
    logic             last_pulse;

    modport source (output valid, output mark_ticks, output space_ticks, output last_pulse,
                    input ready);
    modport sink   (input valid, input mark_ticks, input space_ticks, input last_pulse,
                    output ready);
endinterface

// Configuration write channel.
interface necpb_cfg_if import necpb_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [ADDR_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: design/nec_ir_frame_pulse_builder.sv
// Top level of the NEC infrared frame pulse builder, driven by a microcoded sequencer.
//
//   Channel  Direction  Payload                                   Item
//   cmd      in         command_byte[7:0]                         one byte to send
//   pulse    out        mark_ticks[14:0] space_ticks[14:0] last   one mark/space pair
//   cfg      in         index[0] data[15:0]                       one register write
//
// Each command item yields PAYLOAD_BITS + 2 pulse pairs (34 by default), one per cycle
// unless pulse.ready stalls; the sequencer step counter issues one pair a cycle when not stalled.
// The next command is taken in the cycle the trailer pair is issued.
// Reset leaves the block idle with frame_address 0xFF00 and ticks_per_ten_us 8.
// A stall on pulse.ready freezes the sequencer; the waiting pair is held in the output register.
module nec_ir_frame_pulse_builder
    import necpb_pkg::*;
#(
    parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
)
(
    input  logic           clk,
    input  logic           rst_n,
    necpb_cfg_if.sink      cfg,
    necpb_cmd_if.sink      cmd,
    necpb_pulse_if.source  pulse
);

    localparam int CNT_W = (PAYLOAD_BITS > 1) ? $clog2(PAYLOAD_BITS) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PAYLOAD_BITS - 1);

    // Configuration registers.
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [TICK_W-1:0] tick_reg, tick_next;

    // Sequencer and datapath state.
    logic                    busy_reg, busy_next;
    logic [UPC_W-1:0]        upc_reg, upc_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [PAYLOAD_BITS-1:0] frame_reg, frame_next;

    // Output register.
    logic             out_valid_reg, out_valid_next;
    logic [DUR_W-1:0] mark_reg;
    logic [DUR_W-1:0] space_reg;
    logic             last_reg;

    uword_t            uword;
    logic              issue;
    logic              frame_done;
    logic              accept;
    logic [31:0]       payload_word;
    logic [BASE_W-1:0] mark_base;
    logic [BASE_W-1:0] space_base;
    logic [PROD_W-1:0] mark_prod;
    logic [PROD_W-1:0] space_prod;
    logic [DUR_W-1:0]  mark_dur;
    logic [DUR_W-1:0]  space_dur;

    // Configuration writes are always taken.
    assign cfg.ready = 1'b1;

    always_comb
    begin
        addr_next = addr_reg;
        tick_next = tick_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_FRAME_ADDRESS:    addr_next = cfg.data;
                CFG_TICKS_PER_TEN_US: tick_next = cfg.data[TICK_W-1:0];
                default:              addr_next = addr_reg;
            endcase
        end
    end

    // Current control word and handshake decisions.
    assign uword        = ucode_rom(upc_reg);
    assign issue        = busy_reg && (!out_valid_reg || pulse.ready);
    assign frame_done   = issue && uword.end_frame;
    assign cmd.ready    = !busy_reg || frame_done;
    assign accept       = cmd.valid && cmd.ready;
    assign payload_word = {~cmd.command_byte, cmd.command_byte, addr_reg};

    // Step counter, bit counter and payload shifter.
    always_comb
    begin
        busy_next  = busy_reg;
        upc_next   = upc_reg;
        cnt_next   = cnt_reg;
        frame_next = frame_reg;
        if (accept)
        begin
            busy_next  = 1'b1;
            upc_next   = STEP_HEADER;
            cnt_next   = '0;
            frame_next = payload_word[PAYLOAD_BITS-1:0];
        end
        else if (frame_done)
        begin
            busy_next = 1'b0;
        end
        else if (issue)
        begin
            if (uword.shift)
            begin
                frame_next = frame_reg >> 1;
                cnt_next   = cnt_reg + CNT_W'(1);
            end
            if (uword.br_cond == BR_BITS_LEFT && cnt_reg != CNT_LAST)
                upc_next = uword.br_target;
            else
                upc_next = upc_reg + UPC_W'(1);
        end
    end

    // Durations in 10 us units selected by the control word.
    always_comb
    begin
        unique case (uword.mark_sel)
            MARK_HDR: mark_base = HDR_MARK_U;
            MARK_BIT: mark_base = BIT_MARK_U;
            default:  mark_base = BIT_MARK_U;
        endcase
        unique case (uword.space_sel)
            SPACE_HDR:  space_base = HDR_SPACE_U;
            SPACE_DATA: space_base = frame_reg[0] ? ONE_SPACE_U : ZERO_SPACE_U;
            SPACE_NONE: space_base = '0;
            default:    space_base = '0;
        endcase
    end

    // Scale to ticks and saturate to the field width.
    assign mark_prod  = PROD_W'(mark_base) * PROD_W'(tick_reg);
    assign space_prod = PROD_W'(space_base) * PROD_W'(tick_reg);
    assign mark_dur   = (mark_prod > PROD_W'(DUR_MAX)) ? DUR_MAX : mark_prod[DUR_W-1:0];
    assign space_dur  = (space_prod > PROD_W'(DUR_MAX)) ? DUR_MAX : space_prod[DUR_W-1:0];

    // Output valid follows issue and the downstream ready.
    always_comb
    begin
        if (issue)
            out_valid_next = 1'b1;
        else if (pulse.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Control and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg      <= ADDR_RESET;
            tick_reg      <= TICK_RESET;
            busy_reg      <= 1'b0;
            upc_reg       <= STEP_HEADER;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            addr_reg      <= addr_next;
            tick_reg      <= tick_next;
            busy_reg      <= busy_next;
            upc_reg       <= upc_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        frame_reg <= frame_next;
        if (issue)
        begin
            mark_reg  <= mark_dur;
            space_reg <= space_dur;
            last_reg  <= uword.last;
        end
    end

    assign pulse.valid       = out_valid_reg;
    assign pulse.mark_ticks  = mark_reg;
    assign pulse.space_ticks = space_reg;
    assign pulse.last_pulse  = last_reg;

endmodule
